// ===== hw/rtl/plds_pkg.sv =====
// Shared types and constants for the pixel lerp, smoothing and dither core.
package plds_pkg;

    localparam int CHAN_W = 8;
    localparam int WEIGHT_W = 13;
    localparam int THR_W = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 13;

    localparam int WEIGHT_FRAC_BITS_DEF = 12;

    localparam int SMOOTH_PERCENT = 95;
    localparam int PERCENT_BASE = 100;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_ENABLE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_CUT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_CUT = 8'd3;

    localparam logic [WEIGHT_W-1:0] UPPER_CUT_RESET = 13'd4095;
    localparam logic [WEIGHT_W-1:0] LOWER_CUT_RESET = 13'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

endpackage

// ===== hw/rtl/plds_if.sv =====
// Handshake interfaces for the pixel input, result output and configuration channels.
interface plds_in_if;
    import plds_pkg::*;

    logic valid;
    logic ready;
    logic [CHAN_W-1:0] first_red;
    logic [CHAN_W-1:0] first_green;
    logic [CHAN_W-1:0] first_blue;
    logic [CHAN_W-1:0] first_alpha;
    logic [CHAN_W-1:0] second_red;
    logic [CHAN_W-1:0] second_green;
    logic [CHAN_W-1:0] second_blue;
    logic [CHAN_W-1:0] second_alpha;
    logic [WEIGHT_W-1:0] weight;
    logic [THR_W-1:0] dither_threshold;

    modport source (
        output valid, first_red, first_green, first_blue, first_alpha,
        output second_red, second_green, second_blue, second_alpha,
        output weight, dither_threshold,
        input ready
    );

    modport sink (
        input valid, first_red, first_green, first_blue, first_alpha,
        input second_red, second_green, second_blue, second_alpha,
        input weight, dither_threshold,
        output ready
    );
endinterface

interface plds_out_if;
    import plds_pkg::*;

    logic valid;
    logic ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input ready
    );

    modport sink (
        input valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

interface plds_cfg_if;
    import plds_pkg::*;

    logic valid;
    logic ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input ready
    );

    modport sink (
        input valid, index, data,
        output ready
    );
endinterface

// ===== hw/rtl/plds_lerp.sv =====
// Per-channel linear blend of two RGBA pixels with a fixed-point weight; the result is truncated.
module plds_lerp #(
    parameter int WEIGHT_FRAC_BITS = plds_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  plds_pkg::pixel_t              x,
    input  plds_pkg::pixel_t              y,
    input  logic [WEIGHT_FRAC_BITS:0]     w,
    output plds_pkg::pixel_t              z
);
    import plds_pkg::*;

    localparam int SW = WEIGHT_FRAC_BITS + 1;
    localparam int PW = SW + CHAN_W + 1;
    localparam logic [SW-1:0] ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

    logic [SW-1:0] w_inv;

    assign w_inv = ONE - w;

    function automatic logic [CHAN_W-1:0] blend(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [SW-1:0]     wi,
        input logic [SW-1:0]     wf
    );
        logic [PW-1:0] acc;
        acc = PW'(a) * PW'(wi) + PW'(b) * PW'(wf);
        return acc[WEIGHT_FRAC_BITS +: CHAN_W];
    endfunction

    assign z.red   = blend(x.red,   y.red,   w_inv, w);
    assign z.green = blend(x.green, y.green, w_inv, w);
    assign z.blue  = blend(x.blue,  y.blue,  w_inv, w);
    assign z.alpha = blend(x.alpha, y.alpha, w_inv, w);

endmodule

// ===== hw/rtl/pixel_lerp_smooth_dither_core.sv =====
// Top level of the pixel lerp core with endpoint smoothing and threshold dither.
// The pixels channel carries two RGBA pixels, a blend weight in unsigned fixed
// point with WEIGHT_FRAC_BITS fraction bits, and a dither threshold byte.
// The result channel carries one RGBA pixel for every item taken in.
// The cfg channel writes smooth_enable, dither_enable, upper_cut and lower_cut
// by index; it is always ready, and writes to unknown indexes are dropped.
// The user must change configuration only while no item is in flight; the core
// does not enforce it. Each item passes through three register stages: weight
// saturation, cut compares and the smoothing weight products, then the endpoint
// smoothing blends, then the final blend or dither pick into the output register.
// An item moves from the stage one registers to stage two, then to the output
// register; one item is taken in every cycle while the receiver keeps up.
// When the receiver stalls, the whole pipeline holds in place and pixels.ready
// drops, so no item is lost or repeated; ready returns as soon as the output
// register is emptied.
// Reset empties the pipeline and returns the registers to smoothing off,
// dither off, an upper cut of 4095 and a lower cut of 1.
module pixel_lerp_smooth_dither_core #(
    parameter int WEIGHT_FRAC_BITS = plds_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    plds_in_if.sink    pixels,
    plds_out_if.source result,
    plds_cfg_if.sink   cfg
);
    import plds_pkg::*;

    localparam int SW = WEIGHT_FRAC_BITS + 1;
    localparam int CW = (SW > WEIGHT_W) ? SW : WEIGHT_W;
    localparam int MW = SW + WEIGHT_FRAC_BITS;
    localparam int DW = SW + THR_W;
    localparam logic [SW-1:0] ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam int FACTOR_INT = (SMOOTH_PERCENT * (1 << WEIGHT_FRAC_BITS)) / PERCENT_BASE;
    localparam logic [WEIGHT_FRAC_BITS-1:0] FACTOR = FACTOR_INT[WEIGHT_FRAC_BITS-1:0];
    localparam logic [THR_W-1:0] THR_FULL = {THR_W{1'b1}};

    logic                smooth_enable_reg;
    logic                dither_enable_reg;
    logic [WEIGHT_W-1:0] upper_cut_reg;
    logic [WEIGHT_W-1:0] lower_cut_reg;

    logic advance;

    logic [CW-1:0] weight_ext;
    logic [SW-1:0] w_sat;
    logic [SW-1:0] w_inv;
    logic [MW-1:0] prod_a;
    logic [MW-1:0] prod_b;
    logic [DW-1:0] dither_lhs;
    logic [DW-1:0] dither_rhs;
    logic          sel_b_next;
    logic          sel_a_next;
    pixel_t        first_px;
    pixel_t        second_px;

    logic          s1_valid_reg;
    pixel_t        s1_a_reg;
    pixel_t        s1_b_reg;
    logic [SW-1:0] s1_w_reg;
    logic [SW-1:0] s1_wa_reg;
    logic [SW-1:0] s1_wb_reg;
    logic          s1_sel_a_reg;
    logic          s1_sel_b_reg;
    logic          s1_pick_reg;

    pixel_t        smooth_a;
    pixel_t        smooth_b;
    pixel_t        s2_a_next;
    pixel_t        s2_b_next;

    logic          s2_valid_reg;
    pixel_t        s2_a_reg;
    pixel_t        s2_b_reg;
    logic [SW-1:0] s2_w_reg;
    logic          s2_pick_reg;

    pixel_t        lerp_px;
    pixel_t        out_next;

    logic          s3_valid_reg;
    pixel_t        out_reg;

    assign advance = !s3_valid_reg || result.ready;
    assign pixels.ready = advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_enable_reg <= 1'b0;
            dither_enable_reg <= 1'b0;
            upper_cut_reg <= UPPER_CUT_RESET;
            lower_cut_reg <= LOWER_CUT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SMOOTH_ENABLE: smooth_enable_reg <= cfg.data[0];
                REG_DITHER_ENABLE: dither_enable_reg <= cfg.data[0];
                REG_UPPER_CUT:     upper_cut_reg <= cfg.data[WEIGHT_W-1:0];
                REG_LOWER_CUT:     lower_cut_reg <= cfg.data[WEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Stage one saturates the weight and settles every decision made on it.
    assign weight_ext = CW'(pixels.weight);
    assign w_sat = (weight_ext > CW'(ONE)) ? ONE : weight_ext[SW-1:0];
    assign w_inv = ONE - w_sat;
    assign prod_a = MW'(w_sat) * MW'(FACTOR);
    assign prod_b = MW'(w_inv) * MW'(FACTOR);
    assign dither_lhs = DW'(w_sat) * DW'(THR_FULL);
    assign dither_rhs = DW'(pixels.dither_threshold) << WEIGHT_FRAC_BITS;
    assign sel_b_next = CW'(w_sat) >= CW'(upper_cut_reg);
    assign sel_a_next = !sel_b_next && (CW'(w_sat) <= CW'(lower_cut_reg));

    assign first_px = '{red: pixels.first_red, green: pixels.first_green,
                        blue: pixels.first_blue, alpha: pixels.first_alpha};
    assign second_px = '{red: pixels.second_red, green: pixels.second_green,
                         blue: pixels.second_blue, alpha: pixels.second_alpha};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_a_reg <= first_px;
            s1_b_reg <= second_px;
            s1_w_reg <= w_sat;
            s1_wa_reg <= prod_a[WEIGHT_FRAC_BITS +: SW];
            s1_wb_reg <= prod_b[WEIGHT_FRAC_BITS +: SW];
            s1_sel_a_reg <= sel_a_next;
            s1_sel_b_reg <= sel_b_next;
            s1_pick_reg <= dither_lhs > dither_rhs;
        end
    end

    // Stage two pulls the endpoints together; a cut makes both endpoints the chosen pixel.
    plds_lerp #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_smooth_a (
        .x (s1_a_reg),
        .y (s1_b_reg),
        .w (s1_wa_reg),
        .z (smooth_a)
    );

    plds_lerp #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_smooth_b (
        .x (s1_b_reg),
        .y (s1_a_reg),
        .w (s1_wb_reg),
        .z (smooth_b)
    );

    always_comb
    begin
        if (s1_sel_b_reg)
        begin
            s2_a_next = s1_b_reg;
            s2_b_next = s1_b_reg;
        end
        else if (s1_sel_a_reg)
        begin
            s2_a_next = s1_a_reg;
            s2_b_next = s1_a_reg;
        end
        else if (smooth_enable_reg)
        begin
            s2_a_next = smooth_a;
            s2_b_next = smooth_b;
        end
        else
        begin
            s2_a_next = s1_a_reg;
            s2_b_next = s1_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_a_reg <= s2_a_next;
            s2_b_reg <= s2_b_next;
            s2_w_reg <= s1_w_reg;
            s2_pick_reg <= s1_pick_reg;
        end
    end

    // Stage three forms the result into the output register.
    plds_lerp #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_final (
        .x (s2_a_reg),
        .y (s2_b_reg),
        .w (s2_w_reg),
        .z (lerp_px)
    );

    always_comb
    begin
        if (dither_enable_reg)
        begin
            out_next = s2_pick_reg ? s2_b_reg : s2_a_reg;
        end
        else
        begin
            out_next = lerp_px;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixels.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign result.valid = s3_valid_reg;
    assign result.out_red = out_reg.red;
    assign result.out_green = out_reg.green;
    assign result.out_blue = out_reg.blue;
    assign result.out_alpha = out_reg.alpha;

`ifndef SYNTHESIS
    a_stall_keeps_items: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (s1_valid_reg == $past(s1_valid_reg))
                     && (s2_valid_reg == $past(s2_valid_reg)))
        else $error("pipeline item changed while the output was stalled");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.ready == (!result.valid || result.ready))
        else $error("input ready does not follow the output register state");

    a_cuts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_sel_a_reg && s1_sel_b_reg))
        else $error("both cut selections active for one item");

    a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.ready) ##1 advance ##1 advance |=> result.valid)
        else $error("accepted item did not reach the output register");
`endif

endmodule
